>>> hw/rtl/pxd_pkg.sv
// Shared types and constants for the pixel readout word decoder.
package pxd_pkg;

	localparam int          NUM_CHANNELS_DEF = 8;
	localparam int          HIT_FIFO_DEPTH   = 4;

	localparam logic [4:0]  COUNT_MAX        = 5'd16;
	localparam logic [3:0]  TOT_NONE         = 4'hF;
	localparam logic [3:0]  TAG_MAX          = 4'd15;
	localparam logic [6:0]  COL_LIMIT        = 7'd80;
	localparam logic [8:0]  ROW_LIMIT_SINGLE = 9'd336;
	localparam logic [8:0]  ROW_LIMIT_PAIR   = 9'd335;

	localparam logic [7:0]  HEADER_CODE_RST  = 8'd233;
	localparam logic [7:0]  ADDRESS_CODE_RST = 8'd234;
	localparam logic [7:0]  VALUE_CODE_RST   = 8'd236;
	localparam logic [7:0]  SERVICE_CODE_RST = 8'd239;

	typedef enum logic [1:0] {
		REG_HEADER,
		REG_ADDRESS,
		REG_VALUE,
		REG_SERVICE
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] header_code;
		logic [7:0] address_code;
		logic [7:0] value_code;
		logic [7:0] service_code;
	} cfg_t;

	typedef struct packed {
		logic [6:0] column;
		logic [8:0] row;
		logic [3:0] tot;
		logic [3:0] tag;
		logic [2:0] channel;
		logic       last;
	} hit_t;

	typedef struct packed {
		logic [1:0] count;
		hit_t       first;
		hit_t       second;
	} hit_pair_t;

endpackage

>>> hw/rtl/pxd_decoder.sv
// Word decode, per-channel header counters and hit formation.
module pxd_decoder #(
	parameter int NUM_CHANNELS = pxd_pkg::NUM_CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        word,
	input  logic               fire,
	input  pxd_pkg::cfg_t      cfg,
	output pxd_pkg::hit_pair_t pair
);
	import pxd_pkg::*;

	localparam int         CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [7:0] NCH  = 8'(NUM_CHANNELS);

	logic [4:0]      count_q [NUM_CHANNELS];
	logic [7:0]      ch8;
	logic [7:0]      rec_type;
	logic [CH_W-1:0] idx;
	logic            is_trig;
	logic            ch_ok;
	logic            is_hdr;
	logic            is_skip;
	logic            rec_ok;
	logic            is_data;
	logic            inc;
	logic [6:0]      col;
	logic [8:0]      row;
	logic [3:0]      tot1;
	logic [3:0]      tot2;
	logic [4:0]      cnt;
	logic [3:0]      tag;

	always_comb begin
		ch8      = word[31:24];
		rec_type = word[23:16];
		is_trig  = word[31];
		ch_ok    = ch8 < NCH;
		idx      = ch8[CH_W-1:0];
		is_hdr   = rec_type == cfg.header_code;
		is_skip  = (rec_type == cfg.address_code) || (rec_type == cfg.value_code) ||
		           (rec_type == cfg.service_code);
		tot2     = word[3:0];
		tot1     = word[7:4];
		row      = word[16:8] - 9'd1;
		col      = word[23:17] - 7'd1;
		rec_ok   = (col < COL_LIMIT) &&
		           (((tot2 == TOT_NONE) && (row < ROW_LIMIT_SINGLE)) ||
		            ((tot2 != TOT_NONE) && (row < ROW_LIMIT_PAIR)));
		cnt      = count_q[idx];
		tag      = (cnt == 5'd0) ? TAG_MAX : cnt[3:0] - 4'd1;
		is_data  = !is_trig && ch_ok && !is_hdr && !is_skip && rec_ok;
		inc      = !is_trig && ch_ok && is_hdr && (cnt < COUNT_MAX);

		pair.first  = '{column: col, row: row + 9'd1, tot: tot2, tag: tag,
		                channel: ch8[2:0], last: 1'b0};
		pair.second = '{column: col, row: row, tot: tot1, tag: tag,
		                channel: ch8[2:0], last: 1'b1};
		if (!is_data) begin
			pair.count = 2'd0;
		end else if (tot2 == TOT_NONE) begin
			pair.count = 2'd1;
		end else begin
			pair.count = 2'd2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				count_q[i] <= 5'd0;
			end
		end else if (fire && is_trig) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				count_q[i] <= 5'd0;
			end
		end else if (fire && inc) begin
			count_q[idx] <= cnt + 5'd1;
		end
	end

endmodule

>>> hw/rtl/pxd_hit_fifo.sv
// Result queue taking up to two hits per transfer and giving one.
module pxd_hit_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pxd_pkg::hit_pair_t pair,
	output logic               space,
	output logic               out_valid,
	input  logic               out_ready,
	output pxd_pkg::hit_t      out_hit
);
	import pxd_pkg::*;

	localparam int PTR_W = $clog2(HIT_FIFO_DEPTH);
	localparam int CNT_W = $clog2(HIT_FIFO_DEPTH + 1);

	hit_t             mem_q [HIT_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_next;
	logic [CNT_W-1:0] n_push;
	logic             pop;

	assign wr_next   = PTR_W'(wr_ptr_q + 1'b1);
	assign n_push    = push ? CNT_W'(pair.count) : '0;
	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign out_hit   = mem_q[rd_ptr_q];
	assign space     = count_q <= CNT_W'(HIT_FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push) begin
			case (pair.count)
				2'd2: begin
					mem_q[wr_ptr_q] <= pair.first;
					mem_q[wr_next]  <= pair.second;
				end
				2'd1: begin
					mem_q[wr_ptr_q] <= pair.second;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + n_push);
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= count_q + n_push - CNT_W'(pop);
		end
	end

endmodule

>>> hw/rtl/pixel_readout_word_decoder.sv
// Top level: register port, input register, decoder and result queue.
// A word goes through the input register, then its hits into the result queue.
// Throughput: one word per cycle; hits leave at one per cycle while out_ready
// is high, and the input stalls while the four-entry result queue holds three
// or more hits, so a steady run of two-hit words is paced by the hit output.
// Reset: header counters clear, type codes take their defaults, queue empties.
module pixel_readout_word_decoder #(
	parameter int NUM_CHANNELS = pxd_pkg::NUM_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] raw_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  hit_column,
	output logic [8:0]  hit_row,
	output logic [3:0]  hit_tot,
	output logic [3:0]  trigger_tag,
	output logic [2:0]  hit_channel,
	output logic        last_hit,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pxd_pkg::*;

	cfg_t      cfg_q;
	reg_idx_t  reg_idx;
	logic      wr_en;
	logic [7:0] rd_val;
	logic [31:0] word_s1;
	logic      valid_s1;
	logic      space;
	logic      advance;
	hit_pair_t pair;
	hit_t      out_hit;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;

	always_comb begin
		case (reg_idx)
			REG_HEADER:  rd_val = cfg_q.header_code;
			REG_ADDRESS: rd_val = cfg_q.address_code;
			REG_VALUE:   rd_val = cfg_q.value_code;
			REG_SERVICE: rd_val = cfg_q.service_code;
			default:     rd_val = 8'd0;
		endcase
		prdata = {24'd0, rd_val};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_code  <= HEADER_CODE_RST;
			cfg_q.address_code <= ADDRESS_CODE_RST;
			cfg_q.value_code   <= VALUE_CODE_RST;
			cfg_q.service_code <= SERVICE_CODE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HEADER:  cfg_q.header_code  <= pwdata[7:0];
				REG_ADDRESS: cfg_q.address_code <= pwdata[7:0];
				REG_VALUE:   cfg_q.value_code   <= pwdata[7:0];
				REG_SERVICE: cfg_q.service_code <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign advance  = valid_s1 && space;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= raw_word;
		end
	end

	pxd_decoder #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_decoder (
		.clk   (clk),
		.arst_n(arst_n),
		.word  (word_s1),
		.fire  (advance),
		.cfg   (cfg_q),
		.pair  (pair)
	);

	pxd_hit_fifo u_hit_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance),
		.pair     (pair),
		.space    (space),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_hit  (out_hit)
	);

	assign hit_column  = out_hit.column;
	assign hit_row     = out_hit.row;
	assign hit_tot     = out_hit.tot;
	assign trigger_tag = out_hit.tag;
	assign hit_channel = out_hit.channel;
	assign last_hit    = out_hit.last;

endmodule

>>> bench/pixel_readout_word_decoder_tb.sv
// Testbench for the pixel readout word decoder: directed table and random words.
`timescale 1ns / 100ps

module pixel_readout_word_decoder_tb;

	import pxd_pkg::*;

	localparam int HOLD_CYCLES     = 250;
	localparam int DRAIN_LIMIT     = 5000;
	localparam int PHASES          = 6;
	localparam int WORDS_PER_PHASE = 135;
	localparam int QUIET_WORDS     = 100;
	localparam int FLOOD_WORDS     = 60;

	typedef struct {
		logic [31:0] word;
		bit          given;
		int          hits;
		hit_t        first;
		hit_t        second;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] raw_word;
	logic        out_valid;
	logic        out_ready;
	logic [6:0]  hit_column;
	logic [8:0]  hit_row;
	logic [3:0]  hit_tot;
	logic [3:0]  trigger_tag;
	logic [2:0]  hit_channel;
	logic        last_hit;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cfg_t        codes = '{HEADER_CODE_RST, ADDRESS_CODE_RST, VALUE_CODE_RST, SERVICE_CODE_RST};
	logic [4:0]  hdr_count [NUM_CHANNELS_DEF];
	hit_t        expected_hits [$];
	stim_row_t   offered [$];
	int unsigned mismatches = 0;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;

	stim_row_t directed_rows [24] = '{
		'{32'h00020100, 1'b1, 2, '{0, 1, 0, 15, 0, 0}, '{0, 0, 0, 15, 0, 1}},
		'{32'h07A14FAE, 1'b1, 2, '{79, 335, 14, 15, 7, 0}, '{79, 334, 10, 15, 7, 1}},
		'{32'h030B50FF, 1'b1, 1, '{4, 335, 15, 15, 3, 1}, '0},
		'{32'h030B50FE, 1'b1, 0, '0, '0},
		'{32'h000200FF, 1'b1, 0, '0, '0},
		'{32'h00000110, 1'b1, 0, '0, '0},
		'{32'h00A20100, 1'b1, 0, '0, '0},
		'{32'h02E90000, 1'b1, 0, '0, '0},
		'{32'h02141435, 1'b0, 0, '0, '0},
		'{32'h02E9FFFF, 1'b1, 0, '0, '0},
		'{32'h02141435, 1'b0, 0, '0, '0},
		'{32'h00EA0100, 1'b1, 0, '0, '0},
		'{32'h00EC0100, 1'b1, 0, '0, '0},
		'{32'h00EF0100, 1'b1, 0, '0, '0},
		'{32'h08020100, 1'b1, 0, '0, '0},
		'{32'h7F020100, 1'b1, 0, '0, '0},
		'{32'h08E90000, 1'b1, 0, '0, '0},
		'{32'h80000000, 1'b1, 0, '0, '0},
		'{32'h02141435, 1'b1, 2, '{9, 20, 5, 15, 2, 0}, '{9, 19, 3, 15, 2, 1}},
		'{32'hFFFFFFFF, 1'b1, 0, '0, '0},
		'{32'h010201FF, 1'b1, 1, '{0, 0, 15, 15, 1, 1}, '0},
		'{32'h04074F7F, 1'b0, 0, '0, '0},
		'{32'h05E90000, 1'b0, 0, '0, '0},
		'{32'h05A0013C, 1'b0, 0, '0, '0}
	};

	pixel_readout_word_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.raw_word    (raw_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit_column  (hit_column),
		.hit_row     (hit_row),
		.hit_tot     (hit_tot),
		.trigger_tag (trigger_tag),
		.hit_channel (hit_channel),
		.last_hit    (last_hit),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #6 clk = ~clk;

	initial begin
		foreach (hdr_count[k])
			hdr_count[k] = '0;
	end

	task automatic decode_word(input logic [31:0] w, output int n, output hit_t h0,
			output hit_t h1);
		logic [7:0] chan;
		logic [7:0] rtype;
		logic [3:0] t2;
		logic [3:0] t1;
		logic [3:0] tag;
		logic [4:0] less;
		logic [8:0] row;
		logic [6:0] col;
		hit_t       h;
		n = 0;
		h0 = '0;
		h1 = '0;
		chan = w[31:24];
		rtype = w[23:16];
		if (w[31]) begin
			foreach (hdr_count[k])
				hdr_count[k] = '0;
		end else if (chan >= NUM_CHANNELS_DEF) begin
		end else if (rtype == codes.header_code) begin
			if (hdr_count[chan[2:0]] < COUNT_MAX)
				hdr_count[chan[2:0]] = hdr_count[chan[2:0]] + 5'd1;
		end else if (rtype == codes.address_code || rtype == codes.value_code ||
				rtype == codes.service_code) begin
		end else begin
			t2 = w[3:0];
			t1 = w[7:4];
			row = w[16:8] - 9'd1;
			col = w[23:17] - 7'd1;
			if (col < COL_LIMIT && ((t2 == TOT_NONE && row < ROW_LIMIT_SINGLE) ||
					(t2 < TOT_NONE && row < ROW_LIMIT_PAIR))) begin
				less = hdr_count[chan[2:0]] - 5'd1;
				tag = (hdr_count[chan[2:0]] == 5'd0 || less > 5'(TAG_MAX)) ? TAG_MAX : less[3:0];
				h = '{col, row, t1, tag, chan[2:0], 1'b1};
				if (t2 != TOT_NONE) begin
					h0 = '{col, row + 9'd1, t2, tag, chan[2:0], 1'b0};
					h1 = h;
					n = 2;
				end else begin
					h0 = h;
					n = 1;
				end
			end
		end
	endtask

	task automatic check_hit(hit_t got);
		hit_t want;
		if (expected_hits.size() == 0) begin
			$display("%0t: expected no hit, got col %0d row %0d tot %0d tag %0d ch %0d last %0d",
				$time, got.column, got.row, got.tot, got.tag, got.channel, got.last);
			mismatches++;
		end else begin
			want = expected_hits.pop_front();
			if (want.column !== got.column) begin
				$display("%0t: hit_column expected %0d got %0d", $time, want.column, got.column);
				mismatches++;
			end
			if (want.row !== got.row) begin
				$display("%0t: hit_row expected %0d got %0d", $time, want.row, got.row);
				mismatches++;
			end
			if (want.tot !== got.tot) begin
				$display("%0t: hit_tot expected %0d got %0d", $time, want.tot, got.tot);
				mismatches++;
			end
			if (want.tag !== got.tag) begin
				$display("%0t: trigger_tag expected %0d got %0d", $time, want.tag, got.tag);
				mismatches++;
			end
			if (want.channel !== got.channel) begin
				$display("%0t: hit_channel expected %0d got %0d", $time, want.channel,
					got.channel);
				mismatches++;
			end
			if (want.last !== got.last) begin
				$display("%0t: last_hit expected %0d got %0d", $time, want.last, got.last);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk) begin : monitor
		stim_row_t row;
		int        n;
		hit_t      h0;
		hit_t      h1;
		if (arst_n === 1'b1 && in_valid === 1'b1 && in_ready === 1'b1) begin
			row = offered.pop_front();
			decode_word(raw_word, n, h0, h1);
			if (row.given) begin
				n = row.hits;
				h0 = row.first;
				h1 = row.second;
			end
			if (n > 0)
				expected_hits = {expected_hits, h0};
			if (n > 1)
				expected_hits = {expected_hits, h1};
		end
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
			check_hit('{hit_column, hit_row, hit_tot, trigger_tag, hit_channel, last_hit});
	end

	initial begin
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat (quiet ? 1 : $urandom_range(1, 25)) @(posedge clk);
			end
		end
	end

	task automatic send_word(stim_row_t row, bit may_idle);
		if (may_idle && !quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		offered = {offered, row};
		raw_word <= row.word;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
	endtask

	task automatic wait_quiet();
		int spin;
		spin = 0;
		in_valid <= 1'b0;
		repeat (4) @(posedge clk);
		while (expected_hits.size() != 0 && spin < DRAIN_LIMIT) begin
			@(posedge clk);
			spin++;
		end
		repeat (8) @(posedge clk);
		if (expected_hits.size() != 0) begin
			$display("%0t: %0d expected hits never arrived", $time, expected_hits.size());
			mismatches += expected_hits.size();
			expected_hits.delete();
		end
	endtask

	task automatic reg_write(reg_idx_t idx, logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_HEADER:  codes.header_code = v;
			REG_ADDRESS: codes.address_code = v;
			REG_VALUE:   codes.value_code = v;
			REG_SERVICE: codes.service_code = v;
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic reg_check(reg_idx_t idx, logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[7:0] !== v) begin
			$display("%0t: register %s expected %0d got %0d", $time, idx.name(), v,
				prdata[7:0]);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_codes(cfg_t c);
		reg_write(REG_HEADER, c.header_code);
		reg_write(REG_ADDRESS, c.address_code);
		reg_write(REG_VALUE, c.value_code);
		reg_write(REG_SERVICE, c.service_code);
		reg_check(REG_HEADER, c.header_code);
		reg_check(REG_ADDRESS, c.address_code);
		reg_check(REG_VALUE, c.value_code);
		reg_check(REG_SERVICE, c.service_code);
	endtask

	function automatic logic [31:0] data_record(logic [6:0] chan);
		logic [6:0] colf;
		logic [8:0] rowf;
		logic [3:0] t2;
		colf = ($urandom_range(0, 9) != 0) ? 7'($urandom_range(1, 80)) : 7'($urandom);
		rowf = ($urandom_range(0, 9) != 0) ? 9'($urandom_range(1, 336)) : 9'($urandom);
		t2 = ($urandom_range(0, 4) == 0) ? TOT_NONE : 4'($urandom);
		return {1'b0, chan, colf, rowf, 4'($urandom), t2};
	endfunction

	initial begin
		cfg_t        c;
		stim_row_t   row;
		logic [31:0] w;
		logic [7:0]  ign;
		logic [6:0]  burst_ch;
		int          pick;
		int          burst_left;
		int          flood_left;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		raw_word <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		burst_left = 0;
		flood_left = 0;
		burst_ch = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_check(REG_HEADER, HEADER_CODE_RST);
		reg_check(REG_ADDRESS, ADDRESS_CODE_RST);
		reg_check(REG_VALUE, VALUE_CODE_RST);
		reg_check(REG_SERVICE, SERVICE_CODE_RST);

		foreach (directed_rows[r])
			send_word(directed_rows[r], 1'b1);
		wait_quiet();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: c = '0;
				1: c = '1;
				2: c = '{8'd255, 8'd0, 8'd128, 8'd1};
				5: c = '{HEADER_CODE_RST, ADDRESS_CODE_RST, VALUE_CODE_RST, SERVICE_CODE_RST};
				default: c = '{8'($urandom_range(2, 161)), 8'($urandom_range(2, 161)),
					8'($urandom_range(2, 161)), 8'($urandom_range(2, 161))};
			endcase
			program_codes(c);
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				quiet = (ph == PHASES - 1) && (i >= WORDS_PER_PHASE - QUIET_WORDS);
				if (ph == 2 && i == 40) begin
					hold_req = 1'b1;
					flood_left = FLOOD_WORDS;
				end
				if (flood_left > 0) begin
					w = data_record(7'($urandom_range(0, 7)));
					flood_left--;
				end else if (burst_left > 0) begin
					w = {1'b0, burst_ch, codes.header_code, 16'($urandom)};
					burst_left--;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 3) begin
						burst_ch = 7'($urandom_range(0, 7));
						burst_left = $urandom_range(10, 20);
						w = data_record(burst_ch);
					end else if (pick < 8) begin
						w = {1'b1, 31'($urandom)};
					end else if (pick < 28) begin
						w = {1'b0, 7'($urandom_range(0, 7)), codes.header_code, 16'($urandom)};
					end else if (pick < 36) begin
						case ($urandom_range(0, 2))
							0: ign = codes.address_code;
							1: ign = codes.value_code;
							default: ign = codes.service_code;
						endcase
						w = {1'b0, 7'($urandom_range(0, 7)), ign, 16'($urandom)};
					end else if (pick < 43) begin
						w = $urandom;
					end else if (pick < 48) begin
						w = data_record(7'($urandom_range(8, 127)));
					end else begin
						w = data_record(7'($urandom_range(0, 7)));
					end
				end
				row = '{w, 1'b0, 0, '0, '0};
				send_word(row, flood_left == 0);
			end
			wait_quiet();
		end

		if (mismatches == 0)
			$display("** pixel_readout_word_decoder: PASSED **");
		else
			$display("** pixel_readout_word_decoder: FAILED **");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("%0t: timeout", $time);
		$display("** pixel_readout_word_decoder: FAILED **");
		$finish;
	end

endmodule
